>>> hdl/sci_pkg.sv
package sci_pkg;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // index of the fifth and final byte of a value
    localparam logic [2:0] LAST_IDX = 3'd4;

    // word held in the input register
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic [7:0]  code;
        logic [2:0]  idx;
    } sci_item_t;

    // outcome of one step on the held word
    typedef struct packed {
        logic        emit;
        logic        finish;
        logic [7:0]  byte_val;
        logic [31:0] value;
        logic        value_valid;
        logic        last;
    } sci_result_t;

endpackage

>>> hdl/sci_in_stage.sv
module sci_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [31:0]    value_in,
    input  logic [7:0]            byte_in,
    input  logic                  step_fire,
    input  logic                  step_finish,
    output logic                  item_valid,
    output sci_pkg::sci_item_t    item
);
    import sci_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sci_item_t item_reg;
    sci_item_t item_next;
    logic      take;

    // free once the held word takes its final step
    assign in_stall = valid_reg && !(step_fire && step_finish);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (step_fire && step_finish)
        begin
            valid_next = 1'b0;
        end
        else if (step_fire)
        begin
            item_next.idx = item_reg.idx + 3'd1;
        end
        if (take)
        begin
            valid_next     = 1'b1;
            item_next.neg  = value_in[31];
            item_next.mag  = value_in[31] ? (32'd0 - $unsigned(value_in))
                                          : $unsigned(value_in);
            item_next.code = byte_in;
            item_next.idx  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hdl/sci_step.sv
module sci_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  direction,
    input  logic                  cfg_clear,
    input  logic                  fire,
    input  sci_pkg::sci_item_t    item,
    output sci_pkg::sci_result_t  res
);
    import sci_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [2:0]  pos_reg;
    logic [2:0]  pos_next;
    logic        neg_reg;
    logic        neg_next;

    logic        more;
    logic [6:0]  chunk;
    logic [7:0]  enc_byte;
    logic [31:0] acc_new;
    logic        neg_new;
    logic        done;
    logic [31:0] dec_value;

    // encode: magnitude bits above the current byte decide the continue flag
    always_comb
    begin
        case (item.idx)
            3'd0:    more = |item.mag[31:6];
            3'd1:    more = |item.mag[31:13];
            3'd2:    more = |item.mag[31:20];
            3'd3:    more = |item.mag[31:27];
            default: more = 1'b0;
        endcase
        case (item.idx)
            3'd1:    chunk = item.mag[12:6];
            3'd2:    chunk = item.mag[19:13];
            3'd3:    chunk = item.mag[26:20];
            default: chunk = {2'b00, item.mag[31:27]};
        endcase
        if (item.idx == 3'd0)
        begin
            enc_byte = {more, item.neg, item.mag[5:0]};
        end
        else
        begin
            enc_byte = {more, chunk};
        end
    end

    // decode: merge the byte into the accumulator
    always_comb
    begin
        acc_new = acc_reg;
        neg_new = neg_reg;
        case (pos_reg)
            3'd0:
            begin
                acc_new = {26'd0, item.code[5:0]};
                neg_new = item.code[6];
            end
            3'd1:    acc_new = acc_reg | {19'd0, item.code[6:0], 6'd0};
            3'd2:    acc_new = acc_reg | {12'd0, item.code[6:0], 13'd0};
            3'd3:    acc_new = acc_reg | {5'd0, item.code[6:0], 20'd0};
            default: acc_new = acc_reg | {item.code[4:0], 27'd0};
        endcase
        // fifth byte always ends the value
        done      = (pos_reg >= LAST_IDX) || !item.code[7];
        dec_value = neg_new ? (32'd0 - acc_new) : acc_new;
    end

    always_comb
    begin
        if (direction == DIR_ENCODE)
        begin
            res.emit        = 1'b1;
            res.finish      = !more;
            res.byte_val    = enc_byte;
            res.value       = 32'd0;
            res.value_valid = 1'b0;
            res.last        = !more;
        end
        else
        begin
            res.emit        = done;
            res.finish      = 1'b1;
            res.byte_val    = 8'd0;
            res.value       = dec_value;
            res.value_valid = 1'b1;
            res.last        = 1'b1;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        neg_next = neg_reg;
        if (cfg_clear)
        begin
            acc_next = 32'd0;
            pos_next = 3'd0;
            neg_next = 1'b0;
        end
        else if (fire && direction == DIR_DECODE)
        begin
            if (done)
            begin
                acc_next = 32'd0;
                pos_next = 3'd0;
                neg_next = 1'b0;
            end
            else
            begin
                acc_next = acc_new;
                pos_next = pos_reg + 3'd1;
                neg_next = neg_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 32'd0;
            pos_reg <= 3'd0;
            neg_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
    end

endmodule

>>> hdl/signed_compact_index_codec_core.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------------------
// in      | input     | in_valid/in_stall  | value_in, byte_in
// out     | output    | out_valid/out_stall| byte_out, value_out, value_valid, last
// cfg     | input     | cfg_we             | cfg_data (direction: 0 encode, 1 decode)
//
// Encode: 1 to 5 bytes per value via the single byte port, one per cycle unless out stalls.
// Decode: one byte per cycle unless out stalls; a value appears after its final byte.
// A first result is valid once it has passed the input register, then the output register.
// Reset selects encode mode and clears the decode accumulator; a cfg write clears it too.
// A stalled output holds its word and freezes the step; a held input word then stalls in.
module signed_compact_index_codec_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value_in,
    input  logic [7:0]         byte_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         byte_out,
    output logic signed [31:0] value_out,
    output logic               value_valid,
    output logic               last
);
    import sci_pkg::*;

    logic        direction_reg;
    logic        direction_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [31:0] value_reg;
    logic        vvalid_reg;
    logic        last_reg;

    logic        item_valid;
    sci_item_t   item;
    sci_result_t res;
    logic        fire;

    // step the held word when the output register can take a result
    assign fire = item_valid && (!out_valid_reg || !out_stall);

    sci_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value_in    (value_in),
        .byte_in     (byte_in),
        .step_fire   (fire),
        .step_finish (res.finish),
        .item_valid  (item_valid),
        .item        (item)
    );

    sci_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .cfg_clear (cfg_we),
        .fire      (fire),
        .item      (item),
        .res       (res)
    );

    always_comb
    begin
        direction_next = cfg_we ? cfg_data : direction_reg;
        out_valid_next = out_valid_reg;
        if (fire && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
        begin
            byte_reg   <= res.byte_val;
            value_reg  <= res.value;
            vvalid_reg <= res.value_valid;
            last_reg   <= res.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = byte_reg;
    assign value_out   = signed'(value_reg);
    assign value_valid = vvalid_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    // continue flag of an encoded byte is the inverse of last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !vvalid_reg |-> byte_reg[7] == !last_reg)
        else $error("encoded byte continue flag disagrees with last");

    // decoded values always close their word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && vvalid_reg |-> last_reg)
        else $error("decoded value without last");

    // encode never steps past the fifth byte
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && direction_reg == DIR_ENCODE |-> item.idx <= LAST_IDX)
        else $error("encode byte index out of range");

    // a non-final encode step keeps the word held
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res.finish |=> item_valid)
        else $error("word dropped before its final byte");

    // results in encode mode never carry a value
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.emit && direction_reg == DIR_ENCODE |=> !vvalid_reg)
        else $error("encode result flagged as decoded value");
`endif

endmodule
